FILE: design/icsgs_pkg.sv
// Package for the isochronous channel sequence/gap statistics block.
// Holds the queue entry, counter and result types shared by all modules.
// No dependencies.
package icsgs_pkg;

    localparam int CH_W     = 3;
    localparam int SEQ_W    = 16;
    localparam int LEN_W    = 16;
    localparam int CNT_W    = 32;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd251;

    typedef enum logic [0:0] {
        OP_PKT   = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    // one classified item waiting for the back end
    typedef struct packed {
        t_op              op;
        logic [CH_W-1:0]  channel;
        logic [SEQ_W-1:0] seq_num;
        logic             flag_valid;
        logic             flag_lost;
        logic             flag_error;
        logic             bad_len;
    } t_entry;

    typedef struct packed {
        logic [CNT_W-1:0] raw_count;
        logic [CNT_W-1:0] total_count;
        logic [CNT_W-1:0] valid_count;
        logic [CNT_W-1:0] lost_count;
        logic [CNT_W-1:0] error_count;
        logic [CNT_W-1:0] bad_len_count;
        logic [CNT_W-1:0] gap_events;
        logic [CNT_W-1:0] gap_packets;
        logic [CNT_W-1:0] stale_count;
    } t_ctrs;

    typedef struct packed {
        logic [CH_W-1:0] out_channel;
        t_ctrs           ctrs;
    } t_result;

endpackage

FILE: design/icsgs_front.sv
// Front end: accepts input items, holds the max_len register and classifies
// each item (clear command, packet, bad length, out-of-range drop). Uses icsgs_pkg.
module icsgs_front import icsgs_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_cmd,
    input  logic [CH_W-1:0]  i_channel,
    input  logic [SEQ_W-1:0] i_seq_num,
    input  logic             i_flag_valid,
    input  logic             i_flag_lost,
    input  logic             i_flag_error,
    input  logic [LEN_W-1:0] i_packet_len,
    input  logic             i_q_ready,
    output logic             o_in_ready,
    output logic             o_push,
    output t_entry           o_entry
);

    logic [LEN_W-1:0] r_max_len;
    logic             in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    assign in_range   = 32'(i_channel) < CHANNELS;
    assign o_in_ready = i_q_ready;
    // items on channels beyond the table are taken and dropped here
    assign o_push     = i_in_valid && i_q_ready && (i_cmd || in_range);

    always_comb begin
        o_entry.op         = i_cmd ? OP_CLEAR : OP_PKT;
        o_entry.channel    = i_channel;
        o_entry.seq_num    = i_seq_num;
        o_entry.flag_valid = i_flag_valid;
        o_entry.flag_lost  = i_flag_lost;
        o_entry.flag_error = i_flag_error;
        o_entry.bad_len    = (i_packet_len == '0) || (i_packet_len > r_max_len);
    end

endmodule

FILE: design/icsgs_queue.sv
// Two-entry register queue between front and back end.
// Uses icsgs_pkg for the entry type.
module icsgs_queue import icsgs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_ready,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              full;

    assign full    = r_count == (QPTR_W+1)'(QDEPTH);
    assign o_ready = !full;
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0)) else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

FILE: design/icsgs_back.sv
// Back end: per-channel read-modify-write of sequence tracking and counters,
// plus the output register. Uses icsgs_pkg.
module icsgs_back import icsgs_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_entry  i_entry,
    output logic    o_pop,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_result o_result
);

    localparam int IDX_W = $clog2(CHANNELS);

    t_ctrs            r_cnt   [CHANNELS];
    logic [SEQ_W-1:0] r_exp   [CHANNELS];
    logic             r_track [CHANNELS];
    logic             r_out_valid;
    t_result          r_out;

    logic [IDX_W-1:0] idx;
    logic             out_free;
    logic             chan_nz;
    logic [SEQ_W-1:0] delta;
    t_ctrs            cur;
    t_ctrs            n_cnt;

    assign idx      = IDX_W'(i_entry.channel);
    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = i_q_valid && out_free;
    assign chan_nz  = i_entry.channel != '0;
    assign cur      = r_cnt[idx];
    assign delta    = i_entry.seq_num - r_exp[idx];

    always_comb begin
        n_cnt           = cur;
        n_cnt.raw_count = cur.raw_count + 32'd1;
        if (chan_nz) begin
            n_cnt.total_count   = cur.total_count + 32'd1;
            n_cnt.valid_count   = cur.valid_count + 32'(i_entry.flag_valid);
            n_cnt.lost_count    = cur.lost_count + 32'(i_entry.flag_lost);
            n_cnt.error_count   = cur.error_count + 32'(i_entry.flag_error);
            n_cnt.bad_len_count = cur.bad_len_count + 32'(i_entry.bad_len);
            if (r_track[idx]) begin
                // top bit of the 16-bit difference splits forward jumps from stale ones
                if (delta[SEQ_W-1]) begin
                    n_cnt.stale_count = cur.stale_count + 32'd1;
                end else if (delta != '0) begin
                    n_cnt.gap_events  = cur.gap_events + 32'd1;
                    n_cnt.gap_packets = cur.gap_packets + 32'(delta);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_cnt[i]   <= '0;
                r_exp[i]   <= '0;
                r_track[i] <= 1'b0;
            end
        end else if (o_pop) begin
            unique case (i_entry.op)
                OP_CLEAR: begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        r_track[i] <= 1'b0;
                    end
                end
                OP_PKT: begin
                    r_cnt[idx] <= n_cnt;
                    if (chan_nz) begin
                        r_exp[idx]   <= i_entry.seq_num + 16'd1;
                        r_track[idx] <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_pop && (i_entry.op == OP_PKT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.op == OP_PKT) begin
            r_out.out_channel <= i_entry.channel;
            r_out.ctrs        <= n_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_pkt_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.op == OP_PKT) |=> r_out_valid)
        else $error("packet popped without a result");
    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.op == OP_CLEAR) |=> !r_out_valid)
        else $error("clear command produced a result");
    a_downlink_untracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.out_channel == '0) |->
        (r_out.ctrs.total_count == '0 && r_out.ctrs.gap_events == '0 &&
         r_out.ctrs.stale_count == '0))
        else $error("downlink counters moved");
    a_idle_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_pop)
        else $error("pop while output is stalled");

endmodule

FILE: design/iso_channel_seq_gap_stats.sv
// Top level of the isochronous per-channel sequence/gap statistics block.
// Uses icsgs_pkg, icsgs_front, icsgs_queue and icsgs_back.
//
//  channel  | direction | tdata (low bit up)                          | tuser
//  s_axis   | in        | channel, seq_num, flag_valid, flag_lost,    | cmd
//           |           | flag_error, packet_len, 2 zero bits         |
//  m_axis   | out       | out_channel, raw, total, valid, lost, error,| -
//           |           | bad_len, gap_events, gap_packets, stale     |
//  cfg      | in        | i_cfg_wdata = max_len, written on i_cfg_we  | -
//
// One item per cycle sustained while m_axis_tready stays high; an accepted packet
// on an in-range channel or a clear command is held in the queue, then popped into
// the back end's per-channel read-modify-write; a packet updates the counters and
// loads the output register, a clear only ends tracking. Reset clears all counters
// and tracking; max_len returns to 251. A stalled output holds its result; the
// two-entry queue absorbs items until s_axis_tready drops.
module iso_channel_seq_gap_stats import icsgs_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,   // max_len
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // channel[2:0], seq_num[18:3], flag_valid[19], flag_lost[20], flag_error[21],
    // packet_len[37:22], zero[39:38]
    input  logic [39:0]  s_axis_tdata,
    input  logic         s_axis_tuser,  // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_channel[2:0], raw_count[34:3], total_count[66:35], valid_count[98:67],
    // lost_count[130:99], error_count[162:131], bad_len_count[194:163],
    // gap_events[226:195], gap_packets[258:227], stale_count[290:259], zero[295:291]
    output logic [295:0] m_axis_tdata
);

    logic    push;
    logic    q_ready;
    logic    q_valid;
    logic    pop;
    t_entry  f_entry;
    t_entry  q_entry;
    t_result result;

    icsgs_front #(.CHANNELS(CHANNELS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_cmd        (s_axis_tuser),
        .i_channel    (s_axis_tdata[2:0]),
        .i_seq_num    (s_axis_tdata[18:3]),
        .i_flag_valid (s_axis_tdata[19]),
        .i_flag_lost  (s_axis_tdata[20]),
        .i_flag_error (s_axis_tdata[21]),
        .i_packet_len (s_axis_tdata[37:22]),
        .i_q_ready    (q_ready),
        .o_in_ready   (s_axis_tready),
        .o_push       (push),
        .o_entry      (f_entry)
    );

    icsgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    icsgs_back #(.CHANNELS(CHANNELS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_entry     (q_entry),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (result)
    );

    assign m_axis_tdata = {5'b0,
                           result.ctrs.stale_count,
                           result.ctrs.gap_packets,
                           result.ctrs.gap_events,
                           result.ctrs.bad_len_count,
                           result.ctrs.error_count,
                           result.ctrs.lost_count,
                           result.ctrs.valid_count,
                           result.ctrs.total_count,
                           result.ctrs.raw_count,
                           result.out_channel};

endmodule

FILE: tb/sv/iso_channel_seq_gap_stats_tb.sv
// Testbench for iso_channel_seq_gap_stats: per-channel packet counters, sequence gaps, duplicates.
// Directed and random stream traffic with idle and stall bursts; results are checked
// against a local predictor. Depends on icsgs_pkg and the iso_channel_seq_gap_stats RTL.
`timescale 1ns / 100ps

module iso_channel_seq_gap_stats_tb;
    import icsgs_pkg::*;

    localparam int NUM_CH     = 8;
    localparam int QUIET_MAX  = 1000;
    localparam int SETTLE_CYC = 8;

    typedef struct {
        t_op              op;
        logic [CH_W-1:0]  channel;
        logic [SEQ_W-1:0] seq_num;
        logic             flag_valid;
        logic             flag_lost;
        logic             flag_error;
        logic [LEN_W-1:0] packet_len;
    } t_rx_pkt;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [15:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [295:0] m_axis_tdata;

    iso_channel_seq_gap_stats #(.CHANNELS(NUM_CH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state
    t_ctrs            chan_stats    [NUM_CH];
    logic [SEQ_W-1:0] chan_next_seq [NUM_CH];
    logic             chan_tracking [NUM_CH];
    logic [LEN_W-1:0] max_len_cfg = MAX_LEN_RESET;

    // generator's guess of the next in-order number per channel
    logic [SEQ_W-1:0] gen_next [NUM_CH];

    t_rx_pkt rx_pkt_q [$];
    t_result expected_stats_q [$];

    bit idle_en = 1'b1;
    int in_count = 0;
    int mismatches = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void account_packet(input t_rx_pkt p);
        t_ctrs s;
        t_result r;
        logic [SEQ_W-1:0] delta;
        int c;
        if (p.op == OP_CLEAR) begin
            foreach (chan_tracking[i]) chan_tracking[i] = 1'b0;
            return;
        end
        c = int'(p.channel);
        s = chan_stats[c];
        s.raw_count = s.raw_count + 32'd1;
        // downlink only counts raw packets
        if (c != 0) begin
            if (chan_tracking[c]) begin
                delta = p.seq_num - chan_next_seq[c];
                if (delta != '0 && !delta[SEQ_W-1]) begin
                    s.gap_events  = s.gap_events + 32'd1;
                    s.gap_packets = s.gap_packets + {16'd0, delta};
                end else if (delta[SEQ_W-1]) begin
                    s.stale_count = s.stale_count + 32'd1;
                end
            end
            chan_next_seq[c] = p.seq_num + 16'd1;
            chan_tracking[c] = 1'b1;
            s.total_count = s.total_count + 32'd1;
            if (p.flag_valid) s.valid_count = s.valid_count + 32'd1;
            if (p.flag_lost)  s.lost_count  = s.lost_count + 32'd1;
            if (p.flag_error) s.error_count = s.error_count + 32'd1;
            if (p.packet_len == '0 || p.packet_len > max_len_cfg)
                s.bad_len_count = s.bad_len_count + 32'd1;
        end
        chan_stats[c] = s;
        r.out_channel = p.channel;
        r.ctrs = s;
        expected_stats_q.push_back(r);
    endfunction

    function automatic t_rx_pkt random_packet();
        t_rx_pkt p;
        int kind;
        int c;
        c = $urandom_range(0, NUM_CH - 1);
        p.op = ($urandom_range(0, 31) == 0) ? OP_CLEAR : OP_PKT;
        p.channel = CH_W'(c);
        p.flag_valid = 1'($urandom_range(0, 1));
        p.flag_lost  = 1'($urandom_range(0, 1));
        p.flag_error = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: p.packet_len = '0;
            1: p.packet_len = max_len_cfg;
            2: p.packet_len = max_len_cfg + 16'd1;
            3: p.packet_len = 16'hFFFF;
            4: p.packet_len = LEN_W'($urandom_range(0, 65535));
            default: p.packet_len = LEN_W'($urandom_range(1, 300));
        endcase
        kind = $urandom_range(0, 99);
        if (kind < 65)
            p.seq_num = gen_next[c];
        else if (kind < 78)
            p.seq_num = gen_next[c] + 16'($urandom_range(1, 8));
        else if (kind < 84)
            p.seq_num = gen_next[c] + 16'($urandom_range(9, 16'h7FFF));
        else if (kind < 95)
            p.seq_num = gen_next[c] - 16'($urandom_range(0, 16'h8001));
        else
            p.seq_num = SEQ_W'($urandom_range(0, 65535));
        if (p.op == OP_PKT && c != 0)
            gen_next[c] = p.seq_num + 16'd1;
        return p;
    endfunction

    task automatic push_pkt(input t_op op, input int ch, input int seq, input bit fv,
                            input bit fl, input bit fe, input int len);
        t_rx_pkt p;
        p.op = op;
        p.channel = CH_W'(ch);
        p.seq_num = SEQ_W'(seq);
        p.flag_valid = fv;
        p.flag_lost = fl;
        p.flag_error = fe;
        p.packet_len = LEN_W'(len);
        rx_pkt_q.push_back(p);
    endtask

    // clear commands leave nothing to wait for, so let the pipeline empty too
    task automatic drain_and_settle();
        while (rx_pkt_q.size() != 0 || expected_stats_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin : drv
        int gap_left;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                account_packet(rx_pkt_q.pop_front());
                in_count <= in_count + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (rx_pkt_q.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (idle_en && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 6);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= rx_pkt_q[0].op;
                    s_axis_tdata  <= {2'b00, rx_pkt_q[0].packet_len, rx_pkt_q[0].flag_error,
                                      rx_pkt_q[0].flag_lost, rx_pkt_q[0].flag_valid,
                                      rx_pkt_q[0].seq_num, rx_pkt_q[0].channel};
                end
            end
        end
    end

    // receiver and result check
    always @(posedge i_clk) begin : mon
        t_result want;
        int stall_left;
        int hold_left;
        bit held_once;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            held_once = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_stats_q.size() == 0) begin
                    $error("unexpected result item, channel %0d", m_axis_tdata[2:0]);
                    mismatches++;
                end else begin
                    want = expected_stats_q.pop_front();
                    check_field("out_channel",   32'(want.out_channel),
                                32'(m_axis_tdata[2:0]));
                    check_field("raw_count",     want.ctrs.raw_count,     m_axis_tdata[34:3]);
                    check_field("total_count",   want.ctrs.total_count,   m_axis_tdata[66:35]);
                    check_field("valid_count",   want.ctrs.valid_count,   m_axis_tdata[98:67]);
                    check_field("lost_count",    want.ctrs.lost_count,    m_axis_tdata[130:99]);
                    check_field("error_count",   want.ctrs.error_count,   m_axis_tdata[162:131]);
                    check_field("bad_len_count", want.ctrs.bad_len_count, m_axis_tdata[194:163]);
                    check_field("gap_events",    want.ctrs.gap_events,    m_axis_tdata[226:195]);
                    check_field("gap_packets",   want.ctrs.gap_packets,   m_axis_tdata[258:227]);
                    check_field("stale_count",   want.ctrs.stale_count,   m_axis_tdata[290:259]);
                end
            end
            // one long back-pressure stretch so the input side fills and stalls
            if (!held_once && in_count >= 200) begin
                held_once = 1'b1;
                hold_left = 70;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: only counts while traffic is outstanding
    always @(posedge i_clk) begin : wdog
        int quiet;
        if (!i_rst_n) begin
            quiet = 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet = 0;
        end else if (rx_pkt_q.size() != 0 || expected_stats_q.size() != 0) begin
            quiet++;
            if (quiet >= QUIET_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : stim
        logic [LEN_W-1:0] len_plan [5];
        int phase_items [5];
        foreach (chan_stats[i]) begin
            chan_stats[i] = '0;
            chan_next_seq[i] = '0;
            chan_tracking[i] = 1'b0;
            gen_next[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, max_len still at its reset value
        push_pkt(OP_PKT, 0, 16'h0000, 1, 1, 1, 0);
        push_pkt(OP_PKT, 1, 16'h0000, 1, 0, 0, 1);        // first packet, not tracking
        push_pkt(OP_PKT, 1, 16'h0001, 0, 1, 0, 251);      // in order, length at limit
        push_pkt(OP_PKT, 1, 16'h0005, 0, 0, 1, 252);      // gap of 3, length over limit
        push_pkt(OP_PKT, 1, 16'h0005, 1, 1, 1, 0);        // duplicate
        push_pkt(OP_PKT, 1, 16'h8005, 0, 0, 0, 16'hFFFF); // largest forward jump
        push_pkt(OP_PKT, 1, 16'h0006, 1, 0, 1, 100);      // exactly half the number space back
        push_pkt(OP_PKT, 2, 16'hFFFF, 1, 1, 0, 1);
        push_pkt(OP_PKT, 2, 16'h0000, 0, 1, 1, 251);      // wraps in order
        push_pkt(OP_PKT, 2, 16'h0002, 1, 0, 0, 16'hFFFF);
        push_pkt(OP_CLEAR, 5, 16'hFFFF, 1, 1, 1, 16'hFFFF);
        push_pkt(OP_PKT, 1, 16'h1234, 1, 0, 0, 10);       // tracking restarts, no gap
        push_pkt(OP_PKT, 1, 16'h1235, 0, 0, 0, 10);
        push_pkt(OP_PKT, 2, 16'h0010, 0, 0, 0, 10);
        push_pkt(OP_PKT, 7, 16'hAAAA, 1, 0, 0, 16'h5555);
        push_pkt(OP_PKT, 7, 16'h5555, 0, 1, 0, 16'hAAAA);
        push_pkt(OP_PKT, 7, 16'h5556, 0, 0, 1, 16'h00FB);
        push_pkt(OP_PKT, 3, 16'h7FFF, 1, 1, 1, 16'h00FC);
        push_pkt(OP_PKT, 3, 16'h8000, 0, 0, 0, 1);
        push_pkt(OP_CLEAR, 0, 16'h0000, 0, 0, 0, 0);
        push_pkt(OP_PKT, 0, 16'hFFFF, 1, 1, 1, 16'hFFFF);
        push_pkt(OP_PKT, 3, 16'h8000, 1, 1, 1, 0);        // same number after clear
        push_pkt(OP_PKT, 4, 16'h0100, 0, 1, 1, 50);
        push_pkt(OP_PKT, 6, 16'hFFFE, 1, 1, 0, 250);
        drain_and_settle();

        len_plan = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(2, 65534)), MAX_LEN_RESET};
        phase_items = '{150, 150, 100, 200, 150};
        foreach (len_plan[i]) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= len_plan[i];
            max_len_cfg  = len_plan[i];
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            // last phase runs at full rate on both sides
            idle_en = (i != 4);
            repeat (phase_items[i]) rx_pkt_q.push_back(random_packet());
            drain_and_settle();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
